@@ hw/rtl/sfc_pkg.sv @@
// Shared types, sizes and key functions for the space-filling-curve key block.
// Used by every module under hw/rtl; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package sfc_pkg;

    localparam int COORD_BITS   = 21;
    localparam int KEY_W        = 3 * COORD_BITS;
    localparam int BIT_IDX_W    = $clog2(COORD_BITS);
    // Hilbert levels handled by one pipeline stage, and the number of such stages.
    localparam int LVLS_PER_STG = 2;
    localparam int NUM_LVL_STG  = (COORD_BITS - 1 + LVLS_PER_STG - 1) / LVLS_PER_STG;

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef coord_t [2:0]          point_t;   // [0] = x, [1] = y, [2] = z
    typedef logic [KEY_W-1:0]      key_t;
    typedef logic [BIT_IDX_W-1:0]  bit_idx_t;

    typedef enum logic
    {
        CURVE_MORTON  = 1'b0,
        CURVE_HILBERT = 1'b1
    } curve_t;

    // One item as it travels down the pipeline.
    typedef struct packed
    {
        curve_t mode;
        point_t pt;
    } item_t;

    // One invert-or-exchange level of the axes-to-transpose pass at bit b.
    function automatic point_t hilbert_level(point_t p, int b);
        point_t q;
        coord_t low;
        coord_t t;
        q   = p;
        low = (coord_t'(1) << b) - coord_t'(1);
        for (int i = 0; i < 3; i++)
        begin
            if (q[i][b])
            begin
                q[0] = q[0] ^ low;
            end
            else
            begin
                t    = (q[0] ^ q[i]) & low;
                q[0] = q[0] ^ t;
                q[i] = q[i] ^ t;
            end
        end
        return q;
    endfunction

    // Gray encoding, correction pass and most-significant-first interleave.
    function automatic key_t hilbert_key(point_t p);
        point_t q;
        coord_t t;
        key_t   k;
        q    = p;
        q[1] = q[1] ^ q[0];
        q[2] = q[2] ^ q[1];
        // Each correction bit is the parity of all higher bits of the z word.
        for (int j = 0; j < COORD_BITS; j++)
        begin
            t[j] = ^(q[2] >> (j + 1));
        end
        for (int i = 0; i < 3; i++)
        begin
            q[i] = q[i] ^ t;
        end
        for (int b = 0; b < COORD_BITS; b++)
        begin
            k[3*b+2] = q[0][b];
            k[3*b+1] = q[1][b];
            k[3*b]   = q[2][b];
        end
        return k;
    endfunction

    // Plain bit interleave with x in the lowest position of each triple.
    function automatic key_t morton_key(point_t p);
        key_t k;
        for (int b = 0; b < COORD_BITS; b++)
        begin
            k[3*b]   = p[0][b];
            k[3*b+1] = p[1][b];
            k[3*b+2] = p[2][b];
        end
        return k;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/space_filling_curve_key.sv @@
// Top level of the space-filling-curve key block: config register and pipeline.
// Depends on sfc_pkg, sfc_level_stage and sfc_key_stage.
//
//   Channel | Ports                                  | Direction
//   --------+----------------------------------------+----------
//   input   | in_valid, in_ready, coord_x/y/z        | in
//   output  | out_valid, out_ready, curve_key        | out
//   config  | cfg_wr_en, cfg_wr_data                 | in
//
// At 21-bit coordinates the pipeline has ten stages of two Hilbert levels
// each, then one stage for Gray coding and interleave.
// One transaction is accepted per cycle whenever the pipeline can move.
// Reset clears the curve selection to Morton and empties every stage.
// A stall at the output holds each full stage in place; empty stages still
// fill, so bubbles are squeezed out and nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module space_filling_curve_key
    import sfc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic                  cfg_wr_data,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [COORD_BITS-1:0] coord_x,
    input  wire logic [COORD_BITS-1:0] coord_y,
    input  wire logic [COORD_BITS-1:0] coord_z,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [KEY_W-1:0]           curve_key
);

    // The curve selection is sampled into each transaction as it enters, so
    // the mode travels with the coordinates down the pipeline.
    curve_t curve_sel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            curve_sel_reg <= CURVE_MORTON;
        end
        else if (cfg_wr_en)
        begin
            curve_sel_reg <= curve_t'(cfg_wr_data);
        end
    end

    // Link s feeds level stage s; link NUM_LVL_STG feeds the key stage.
    logic  lnk_valid [NUM_LVL_STG+1];
    logic  lnk_ready [NUM_LVL_STG+1];
    item_t lnk_item  [NUM_LVL_STG+1];

    assign lnk_valid[0]     = in_valid;
    assign lnk_item[0].mode = curve_sel_reg;
    assign lnk_item[0].pt   = {coord_z, coord_y, coord_x};
    assign in_ready         = lnk_ready[0];

    // Stage s resolves Hilbert levels from bit COORD_BITS-1-s*LVLS_PER_STG
    // downward; in Morton mode the stages just carry the coordinates along.
    for (genvar s = 0; s < NUM_LVL_STG; s++)
    begin : g_lvl
        sfc_level_stage u_stage
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .first_bit (bit_idx_t'(COORD_BITS - 1 - s * LVLS_PER_STG)),
            .in_valid  (lnk_valid[s]),
            .in_ready  (lnk_ready[s]),
            .in_item   (lnk_item[s]),
            .out_valid (lnk_valid[s+1]),
            .out_ready (lnk_ready[s+1]),
            .out_item  (lnk_item[s+1])
        );
    end

    // The last stage forms the key and is the output register.
    sfc_key_stage u_key
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (lnk_valid[NUM_LVL_STG]),
        .in_ready  (lnk_ready[NUM_LVL_STG]),
        .in_item   (lnk_item[NUM_LVL_STG]),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_key   (curve_key)
    );

    // An accepted transaction always lands in the first stage.
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> lnk_valid[1])
        else $error("accepted transaction missing from first stage");

    // Back-pressure at the input only arises when the first stage is full
    // and cannot drain.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> lnk_valid[1] && !lnk_ready[1])
        else $error("input stalled without a full, blocked first stage");

    // A full last level stage that cannot drain keeps its transaction.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        lnk_valid[NUM_LVL_STG] && !lnk_ready[NUM_LVL_STG] |=> lnk_valid[NUM_LVL_STG])
        else $error("stalled transaction dropped before key stage");

    // The key stage only fills from a valid transaction.
    a_key_src: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid ##1 out_valid |-> $past(lnk_valid[NUM_LVL_STG]))
        else $error("key produced without a source transaction");

endmodule

`default_nettype wire

@@ hw/rtl/sfc_level_stage.sv @@
// One register stage of the Hilbert transpose pipeline: LVLS_PER_STG levels.
// Depends on sfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfc_level_stage
    import sfc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire bit_idx_t first_bit,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire item_t    in_item,
    output logic          out_valid,
    input  wire logic     out_ready,
    output item_t         out_item
);

    logic  valid_reg;
    item_t item_reg;
    item_t item_next;

    // Levels below bit one do not exist; the last stage may run short.
    always_comb
    begin
        int b;
        b         = 0;
        item_next = in_item;
        if (in_item.mode == CURVE_HILBERT)
        begin
            for (int k = 0; k < LVLS_PER_STG; k++)
            begin
                b = int'(first_bit) - k;
                if (b >= 1)
                begin
                    item_next.pt = hilbert_level(item_next.pt, b);
                end
            end
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/sfc_key_stage.sv @@
// Final pipeline stage: Hilbert mode Gray-encodes, corrects and interleaves;
// Morton mode interleaves only. Holds the output register. Depends on sfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sfc_key_stage
    import sfc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire item_t in_item,
    output logic       out_valid,
    input  wire logic  out_ready,
    output key_t       out_key
);

    logic valid_reg;
    key_t key_reg;
    key_t key_next;

    always_comb
    begin
        unique case (in_item.mode)
            CURVE_HILBERT: key_next = hilbert_key(in_item.pt);
            CURVE_MORTON:  key_next = morton_key(in_item.pt);
            default:       key_next = morton_key(in_item.pt);
        endcase
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_key   = key_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            key_reg <= key_next;
        end
    end

endmodule

`default_nettype wire

@@ dv/space_filling_curve_key_test.sv @@
// Self-checking testbench for space_filling_curve_key: Morton and Hilbert keys of 3D points.
// It depends only on sfc_pkg and the block's RTL. The keys are predicted here, bit by bit,
// and checked in order against every output transaction.
`timescale 1ns / 1ps

module space_filling_curve_key_test;

    import sfc_pkg::*;

    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 9;
    localparam int PIPE_LATENCY  = NUM_LVL_STG + 1;
    localparam int IDLE_PERCENT  = 22;
    localparam int PHASE_POINTS  = 170;
    localparam int WATCHDOG_MAX  = 2000;
    localparam int MAX_REPORTS   = 50;

    localparam coord_t COORD_MAX = {COORD_BITS{1'b1}};

    // One point waiting to be sent.
    typedef struct packed
    {
        coord_t x;
        coord_t y;
        coord_t z;
    } coord_triple_t;

    // One key that is owed by the block, with the point and curve it came from.
    typedef struct packed
    {
        curve_t        mode;
        coord_triple_t pt;
        key_t          key;
    } owed_key_t;

    logic   clk         = 1'b0;
    logic   rst_n       = 1'b0;
    logic   cfg_wr_en   = 1'b0;
    logic   cfg_wr_data = 1'b0;
    logic   in_valid    = 1'b0;
    logic   in_ready;
    coord_t coord_x     = '0;
    coord_t coord_y     = '0;
    coord_t coord_z     = '0;
    logic   out_valid;
    logic   out_ready   = 1'b0;
    key_t   curve_key;

    // Set at a rising edge when the point on the input ports was taken, so that the
    // driver knows at the next falling edge that it may move on.
    logic   in_taken    = 1'b0;
    // While set, neither side idles or stalls.
    logic   calm_phase  = 1'b0;

    curve_t          curve_mode     = CURVE_MORTON;
    coord_triple_t   point_queue[$];
    owed_key_t       key_queue[$];
    int              pushed_count   = 0;
    int              accepted_count = 0;
    int              mismatch_count = 0;
    int              idle_cycles    = 0;

    space_filling_curve_key i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .coord_z     (coord_z),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .curve_key   (curve_key)
    );

    always #HALF_PERIOD clk = ~clk;

    // Morton order: bit b of x, y and z lands on key bits 3b, 3b+1 and 3b+2.
    function automatic key_t morton_interleave(coord_triple_t pt);
        key_t k;
        k = '0;
        for (int b = 0; b < COORD_BITS; b++)
        begin
            k[3*b]   = pt.x[b];
            k[3*b+1] = pt.y[b];
            k[3*b+2] = pt.z[b];
        end
        return k;
    endfunction

    // Hilbert distance by the axes-to-transpose method. The levels are walked from the
    // top bit down to bit 1; at each level an axis whose bit is set inverts the low bits
    // of x, and an axis whose bit is clear swaps its low bits with those of x.
    function automatic key_t hilbert_distance(coord_triple_t pt);
        coord_t a[3];
        coord_t low;
        coord_t swap;
        coord_t fix;
        key_t   k;
        a[0] = pt.x;
        a[1] = pt.y;
        a[2] = pt.z;
        for (int b = COORD_BITS - 1; b >= 1; b--)
        begin
            low = (coord_t'(1) << b) - coord_t'(1);
            for (int i = 0; i < 3; i++)
            begin
                if (a[i][b])
                begin
                    a[0] = a[0] ^ low;
                end
                else
                begin
                    swap = (a[0] ^ a[i]) & low;
                    a[0] = a[0] ^ swap;
                    a[i] = a[i] ^ swap;
                end
            end
        end
        // Gray encoding across the three axes.
        a[1] = a[1] ^ a[0];
        a[2] = a[2] ^ a[1];
        // Correction: every set bit of z above bit 0 flips all bits below it.
        fix = '0;
        for (int b = COORD_BITS - 1; b >= 1; b--)
        begin
            if (a[2][b])
            begin
                fix = fix ^ ((coord_t'(1) << b) - coord_t'(1));
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            a[i] = a[i] ^ fix;
        end
        // Transposed words are read out top bit first, x leading each triple.
        k = '0;
        for (int b = 0; b < COORD_BITS; b++)
        begin
            k[3*b+2] = a[0][b];
            k[3*b+1] = a[1][b];
            k[3*b]   = a[2][b];
        end
        return k;
    endfunction

    // Coordinates are drawn from corners, single bits set or cleared, small values and full
    // random words, so that both the uniform and the sparse cases of the curves are hit.
    function automatic coord_t pick_coord();
        coord_t c;
        case ($urandom_range(0, 7))
            0:       c = '0;
            1:       c = COORD_MAX;
            2:       c = coord_t'(1) << $urandom_range(0, COORD_BITS - 1);
            3:       c = ~(coord_t'(1) << $urandom_range(0, COORD_BITS - 1));
            4:       c = coord_t'($urandom_range(0, 15));
            default: c = coord_t'($urandom);
        endcase
        return c;
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatch_count < MAX_REPORTS)
        begin
            $display("[%0t] ERROR: %s", $realtime, msg);
        end
        mismatch_count++;
    endtask

    task automatic add_point(coord_t x, coord_t y, coord_t z);
        coord_triple_t pt;
        pt.x = x;
        pt.y = y;
        pt.z = z;
        point_queue = {point_queue, pt};
        pushed_count++;
    endtask

    // The sender stops here until every point has been taken and every key has come back.
    task automatic wait_for_drain();
        while (accepted_count != pushed_count || key_queue.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // The curve select is only changed with the pipeline empty, so every point in
    // flight was accepted under the mode that the predictor holds for it.
    task automatic set_curve(curve_t mode);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        curve_mode  = mode;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic add_corner_points();
        add_point('0, '0, '0);
        add_point(COORD_MAX, COORD_MAX, COORD_MAX);
        add_point(COORD_MAX, '0, '0);
        add_point('0, COORD_MAX, '0);
        add_point('0, '0, COORD_MAX);
        add_point(21'h155555, 21'h0aaaaa, 21'h155555);
        add_point(21'h0aaaaa, 21'h155555, 21'h0aaaaa);
        add_point(coord_t'(1) << (COORD_BITS - 1), '0, '0);
        add_point('0, '0, coord_t'(1) << (COORD_BITS - 1));
        add_point(coord_t'(1), coord_t'(2), coord_t'(4));
        add_point(COORD_MAX, '0, COORD_MAX);
        add_point(coord_t'(1), coord_t'(1), coord_t'(1));
    endtask

    // Input side. A point stays on the ports until it is taken; after that the driver
    // either presents the next one or idles. The output ready is redrawn every cycle,
    // independently of the input side.
    always @(negedge clk)
    begin : drive_points
        coord_triple_t pt;
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                if (point_queue.size() != 0 &&
                    (calm_phase || $urandom_range(0, 99) >= IDLE_PERCENT))
                begin
                    pt = point_queue.pop_front();
                    in_valid <= 1'b1;
                    coord_x  <= pt.x;
                    coord_y  <= pt.y;
                    coord_z  <= pt.z;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            out_ready <= calm_phase || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // Both channels are sampled at the rising edge. An input transaction queues the key
    // it must produce; an output transaction is checked against the oldest owed key.
    always @(posedge clk)
    begin : check_keys
        owed_key_t fresh;
        owed_key_t oldest;
        if (!rst_n)
        begin
            in_taken <= 1'b0;
        end
        else
        begin
            in_taken <= in_valid && in_ready;
            if (in_valid && in_ready)
            begin
                fresh.mode = curve_mode;
                fresh.pt.x = coord_x;
                fresh.pt.y = coord_y;
                fresh.pt.z = coord_z;
                if (curve_mode == CURVE_HILBERT)
                begin
                    fresh.key = hilbert_distance(fresh.pt);
                end
                else
                begin
                    fresh.key = morton_interleave(fresh.pt);
                end
                key_queue = {key_queue, fresh};
                accepted_count++;
            end
            if (out_valid && out_ready)
            begin
                if (key_queue.size() == 0)
                begin
                    report_mismatch($sformatf("key %h with no point pending", curve_key));
                end
                else
                begin
                    oldest = key_queue.pop_front();
                    if (curve_key !== oldest.key)
                    begin
                        report_mismatch($sformatf("%s (%h,%h,%h): key %h, want %h",
                            oldest.mode.name(), oldest.pt.x, oldest.pt.y, oldest.pt.z,
                            curve_key, oldest.key));
                    end
                end
            end
            // Watchdog: the run is hung if nothing moves for a long time.
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
            begin
                idle_cycles = 0;
            end
            else if (idle_cycles >= WATCHDOG_MAX)
            begin
                $display("Timeout after %0d cycles without a transaction", idle_cycles);
                $display("Simulation FAILED");
                $finish;
            end
            else
            begin
                idle_cycles++;
            end
        end
    end

    // Test sequence: corner points under each curve, then random phases that switch the
    // curve with the pipeline drained, one of them with no idling on either side.
    initial
    begin : sequence_points
        curve_t phase_mode[6];
        phase_mode = '{CURVE_HILBERT, CURVE_MORTON, CURVE_HILBERT,
                       CURVE_HILBERT, CURVE_MORTON, CURVE_HILBERT};
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        set_curve(CURVE_MORTON);
        add_corner_points();
        wait_for_drain();

        set_curve(CURVE_HILBERT);
        add_corner_points();
        wait_for_drain();

        for (int p = 0; p < 6; p++)
        begin
            calm_phase = (p == 2);
            set_curve(phase_mode[p]);
            for (int n = 0; n < PHASE_POINTS; n++)
            begin
                add_point(pick_coord(), pick_coord(), pick_coord());
            end
            wait_for_drain();
        end
        calm_phase = 1'b0;

        // Let any stray key surface before the verdict.
        repeat (PIPE_LATENCY + 8) @(negedge clk);
        if (mismatch_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
